### hw/rtl/avcrx_pkg.sv
// Shared types, constants and command prefix tables for the AVC-LAN frame receiver.
package avcrx_pkg;

  localparam int AddrWidth   = 12;
  localparam int TickWidth   = 12;
  localparam int LenWidth    = 8;
  localparam int ClassWidth  = 4;
  localparam int KindWidth   = 2;
  localparam int ByteWidth   = 8;

  localparam int MaxMessageBytes = 32;
  localparam int QueueDepth      = 2;
  localparam int PatternCount    = 14;
  localparam int DirectedCount   = 9;

  localparam logic [ByteWidth-1:0] UnitTag = 8'h11;

  localparam logic [KindWidth-1:0] EvAck    = 2'd0;
  localparam logic [KindWidth-1:0] EvAccept = 2'd1;
  localparam logic [KindWidth-1:0] EvParity = 2'd2;
  localparam logic [KindWidth-1:0] EvLength = 2'd3;

  localparam logic [ClassWidth-1:0] ClsNone  = 4'd0;
  localparam logic [ClassWidth-1:0] ClsCheck = 4'd11;

  localparam logic [TickWidth-1:0] OneWidthReset = 12'd208;

  localparam logic RegOwnAddress    = 1'b0;
  localparam logic RegOneWidthLimit = 1'b1;

  typedef struct packed {
    logic start;
    logic value;
  } pulse_t;

  typedef struct packed {
    logic [KindWidth-1:0]  kind;
    logic [ClassWidth-1:0] cls;
    logic                  directed;
    logic                  for_us;
    logic [AddrWidth-1:0]  master;
    logic [AddrWidth-1:0]  slave;
    logic [LenWidth-1:0]   length;
    logic [ByteWidth-1:0]  check;
  } result_t;

  // Number of bytes a prefix spans.
  function automatic logic [2:0] prefix_len(input int k);
    logic [2:0] len;
    case (k)
      5:                len = 3'd6;
      6, 7, 8:          len = 3'd5;
      10, 11, 12, 13:   len = 3'd3;
      default:          len = 3'd4;
    endcase
    return len;
  endfunction

  function automatic logic [ClassWidth-1:0] prefix_cls(input int k);
    logic [ClassWidth-1:0] cls;
    case (k)
      0:       cls = 4'd1;
      1:       cls = 4'd2;
      2:       cls = 4'd3;
      3:       cls = 4'd4;
      4:       cls = 4'd5;
      5:       cls = 4'd6;
      6:       cls = 4'd7;
      7:       cls = 4'd8;
      8:       cls = 4'd9;
      9:       cls = 4'd10;
      10:      cls = ClsCheck;
      11:      cls = 4'd12;
      12:      cls = 4'd13;
      13:      cls = 4'd1;
      default: cls = ClsNone;
    endcase
    return cls;
  endfunction

  // Prefix bytes, first byte in the top octet.
  function automatic logic [47:0] prefix_row(input int k);
    logic [47:0] row;
    case (k)
      0:       row = {8'h00, 8'h00, 8'h01, 8'h0A, 16'h0000};
      1:       row = {8'h00, 8'h00, 8'h01, 8'h08, 16'h0000};
      2:       row = {8'h00, 8'h00, 8'h01, 8'h0D, 16'h0000};
      3:       row = {8'h00, 8'h00, 8'h01, 8'h0C, 16'h0000};
      4:       row = {8'h00, 8'h25, 8'h63, 8'h80, 16'h0000};
      5:       row = {8'h00, UnitTag, 8'h63, 8'h42, 8'h01, 8'h00};
      6:       row = {8'h00, UnitTag, 8'h63, 8'h42, 8'h41, 8'h00};
      7:       row = {8'h00, UnitTag, 8'h63, 8'h43, 8'h01, 8'h00};
      8:       row = {8'h00, UnitTag, 8'h63, 8'h43, 8'h41, 8'h00};
      9:       row = {UnitTag, 8'h01, 8'h45, 8'h63, 16'h0000};
      10:      row = {UnitTag, 8'h01, 8'h20, 24'h000000};
      11:      row = {UnitTag, 8'h01, 8'h00, 24'h000000};
      12:      row = {UnitTag, 8'h01, 8'h01, 24'h000000};
      13:      row = {8'h00, 8'h01, 8'h0A, 24'h000000};
      default: row = '0;
    endcase
    return row;
  endfunction

  function automatic logic [ByteWidth-1:0] prefix_byte(input int k, input logic [2:0] idx);
    logic [47:0] row;
    row = prefix_row(k) << {idx, 3'b000};
    return row[47:40];
  endfunction

endpackage

### hw/rtl/avcrx_front.sv
// Front end: configuration registers and pulse-width to bit classification.
module avcrx_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic                             cfg_index,
  input  logic [avcrx_pkg::AddrWidth-1:0]  cfg_data,
  input  logic                             in_valid,
  input  logic [avcrx_pkg::TickWidth-1:0]  pulse_ticks,
  input  logic                             frame_start,
  input  logic                             q_full,
  output logic                             in_stall,
  output logic                             push,
  output avcrx_pkg::pulse_t                push_data,
  output logic [avcrx_pkg::AddrWidth-1:0]  own_address
);

  logic [avcrx_pkg::TickWidth-1:0] one_width_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address     <= '0;
      one_width_limit <= avcrx_pkg::OneWidthReset;
    end else if (cfg_write) begin
      case (cfg_index)
        avcrx_pkg::RegOwnAddress:    own_address     <= cfg_data;
        avcrx_pkg::RegOneWidthLimit: one_width_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall        = q_full;
  assign push            = in_valid && !q_full;
  assign push_data.start = frame_start;
  // Short high pulse reads as one.
  assign push_data.value = (pulse_ticks < one_width_limit);

endmodule

### hw/rtl/avcrx_queue.sv
// Short queue of classified bits between the front end and the frame decoder.
module avcrx_queue #(
  parameter int DEPTH = avcrx_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  avcrx_pkg::pulse_t push_data,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output avcrx_pkg::pulse_t head_data
);

  localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntWidth = $clog2(DEPTH + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);

  avcrx_pkg::pulse_t     slots [DEPTH];
  logic [PtrWidth-1:0]   wr_ptr;
  logic [PtrWidth-1:0]   rd_ptr;
  logic [CntWidth-1:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign full       = (count == CntWidth'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/avcrx_back.sv
// Back end: frame state machine, prefix matching and the result register.
module avcrx_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [avcrx_pkg::AddrWidth-1:0]  own_address,
  input  logic                             head_valid,
  input  avcrx_pkg::pulse_t                head_data,
  output logic                             pop,
  input  logic                             out_stall,
  output logic                             res_valid,
  output avcrx_pkg::result_t               res
);

  localparam logic [3:0] PhIdle   = 4'd0;
  localparam logic [3:0] PhBcast  = 4'd1;
  localparam logic [3:0] PhMaster = 4'd2;
  localparam logic [3:0] PhMpar   = 4'd3;
  localparam logic [3:0] PhSlave  = 4'd4;
  localparam logic [3:0] PhSpar   = 4'd5;
  localparam logic [3:0] PhAck1   = 4'd6;
  localparam logic [3:0] PhCtrl   = 4'd7;
  localparam logic [3:0] PhCpar   = 4'd8;
  localparam logic [3:0] PhAck2   = 4'd9;
  localparam logic [3:0] PhLen    = 4'd10;
  localparam logic [3:0] PhLpar   = 4'd11;
  localparam logic [3:0] PhAck3   = 4'd12;
  localparam logic [3:0] PhData   = 4'd13;
  localparam logic [3:0] PhDpar   = 4'd14;
  localparam logic [3:0] PhAckd   = 4'd15;

  localparam int AW = avcrx_pkg::AddrWidth;
  localparam int LW = avcrx_pkg::LenWidth;
  localparam int BW = avcrx_pkg::ByteWidth;
  localparam int PC = avcrx_pkg::PatternCount;
  localparam logic [LW-1:0] MaxLen = LW'(avcrx_pkg::MaxMessageBytes);

  logic [3:0]      phase, phase_next;
  logic [3:0]      bit_count, bit_count_next;
  logic [AW-1:0]   field_shift, field_shift_next;
  logic            parity_acc, parity_acc_next;
  logic            directed_flag, directed_flag_next;
  logic            for_us_flag, for_us_flag_next;
  logic [AW-1:0]   master_reg, master_reg_next;
  logic [AW-1:0]   slave_reg, slave_reg_next;
  logic [LW-1:0]   length_reg, length_reg_next;
  logic [LW-1:0]   byte_index, byte_index_next;
  logic [PC-1:0]   pattern_alive, pattern_alive_next;
  logic [BW-1:0]   check_byte, check_byte_next;

  logic                                advance;
  logic                                bit_in;
  logic [AW-1:0]                       shift_in;
  logic                                parity_in;
  logic [3:0]                          count_in;
  logic                                emit;
  logic [avcrx_pkg::KindWidth-1:0]     emit_kind;
  logic [avcrx_pkg::ClassWidth-1:0]    emit_cls;
  logic [avcrx_pkg::ClassWidth-1:0]    frame_cls;
  logic [PC-1:0]                       byte_alive;
  logic                                found;

  assign advance   = head_valid && (!res_valid || !out_stall);
  assign pop       = advance;
  assign bit_in    = head_data.value;
  assign shift_in  = {field_shift[AW-2:0], bit_in};
  assign parity_in = parity_acc ^ bit_in;
  assign count_in  = bit_count + 1'b1;

  // First live prefix of the selected set that fits the declared length.
  always_comb begin
    frame_cls = avcrx_pkg::ClsNone;
    found     = 1'b0;
    for (int k = 0; k < PC; k++) begin
      if (!found && ((k < avcrx_pkg::DirectedCount) == for_us_flag) && pattern_alive[k] &&
          (LW'(avcrx_pkg::prefix_len(k)) <= length_reg)) begin
        frame_cls = avcrx_pkg::prefix_cls(k);
        found     = 1'b1;
      end
    end
  end

  // Drop every prefix that disagrees with the byte just completed.
  always_comb begin
    byte_alive = pattern_alive;
    for (int k = 0; k < PC; k++) begin
      if ((byte_index < LW'(avcrx_pkg::prefix_len(k))) &&
          (avcrx_pkg::prefix_byte(k, byte_index[2:0]) != shift_in[BW-1:0])) begin
        byte_alive[k] = 1'b0;
      end
    end
  end

  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    field_shift_next   = field_shift;
    parity_acc_next    = parity_acc;
    directed_flag_next = directed_flag;
    for_us_flag_next   = for_us_flag;
    master_reg_next    = master_reg;
    slave_reg_next     = slave_reg;
    length_reg_next    = length_reg;
    byte_index_next    = byte_index;
    pattern_alive_next = pattern_alive;
    check_byte_next    = check_byte;
    emit               = 1'b0;
    emit_kind          = avcrx_pkg::EvAck;
    emit_cls           = avcrx_pkg::ClsNone;

    if (head_data.start) begin
      directed_flag_next = 1'b0;
      for_us_flag_next   = 1'b0;
      master_reg_next    = '0;
      slave_reg_next     = '0;
      length_reg_next    = '0;
      byte_index_next    = '0;
      check_byte_next    = '0;
      pattern_alive_next = '1;
      phase_next         = PhBcast;
      bit_count_next     = '0;
      field_shift_next   = '0;
      parity_acc_next    = 1'b0;
    end else begin
      case (phase)
        PhMaster, PhSlave, PhCtrl, PhLen, PhData: begin
          field_shift_next = shift_in;
          parity_acc_next  = parity_in;
          bit_count_next   = count_in;
        end
        default: ;
      endcase

      case (phase)
        PhIdle: ;
        PhBcast: begin
          directed_flag_next = bit_in;
          phase_next         = PhMaster;
          bit_count_next     = '0;
          field_shift_next   = '0;
          parity_acc_next    = 1'b0;
        end
        PhMaster: begin
          if (count_in >= 4'd12) begin
            master_reg_next = shift_in;
            phase_next      = PhMpar;
          end
        end
        PhMpar: begin
          if (bit_in != parity_acc) begin
            phase_next = PhIdle;
            emit       = 1'b1;
            emit_kind  = avcrx_pkg::EvParity;
          end else begin
            phase_next       = PhSlave;
            bit_count_next   = '0;
            field_shift_next = '0;
            parity_acc_next  = 1'b0;
          end
        end
        PhSlave: begin
          if (count_in >= 4'd12) begin
            slave_reg_next   = shift_in;
            for_us_flag_next = (shift_in == own_address);
            phase_next       = PhSpar;
          end
        end
        PhSpar, PhCpar: begin
          if (bit_in != parity_acc) begin
            phase_next = PhIdle;
            emit       = 1'b1;
            emit_kind  = avcrx_pkg::EvParity;
          end else if (for_us_flag) begin
            phase_next       = (phase == PhSpar) ? PhCtrl : PhLen;
            bit_count_next   = '0;
            field_shift_next = '0;
            parity_acc_next  = 1'b0;
            emit             = 1'b1;
            emit_kind        = avcrx_pkg::EvAck;
          end else begin
            phase_next = (phase == PhSpar) ? PhAck1 : PhAck2;
          end
        end
        PhAck1, PhAck2: begin
          phase_next       = (phase == PhAck1) ? PhCtrl : PhLen;
          bit_count_next   = '0;
          field_shift_next = '0;
          parity_acc_next  = 1'b0;
        end
        PhCtrl: begin
          if (count_in >= 4'd4) begin
            phase_next = PhCpar;
          end
        end
        PhLen: begin
          if (count_in >= 4'd8) begin
            length_reg_next = shift_in[LW-1:0];
            phase_next      = PhLpar;
          end
        end
        PhLpar: begin
          if (bit_in != parity_acc) begin
            phase_next = PhIdle;
            emit       = 1'b1;
            emit_kind  = avcrx_pkg::EvParity;
          end else if (length_reg > MaxLen) begin
            phase_next = PhIdle;
            emit       = 1'b1;
            emit_kind  = avcrx_pkg::EvLength;
          end else if (!for_us_flag) begin
            phase_next = PhAck3;
          end else if (length_reg == '0) begin
            phase_next = PhIdle;
            emit       = 1'b1;
            emit_kind  = avcrx_pkg::EvAccept;
            emit_cls   = frame_cls;
          end else begin
            phase_next       = PhData;
            bit_count_next   = '0;
            field_shift_next = '0;
            parity_acc_next  = 1'b0;
            emit             = 1'b1;
            emit_kind        = avcrx_pkg::EvAck;
          end
        end
        PhAck3, PhAckd: begin
          if ((phase == PhAck3) ? (length_reg == '0) : (byte_index >= length_reg)) begin
            phase_next = PhIdle;
            emit       = 1'b1;
            emit_kind  = avcrx_pkg::EvAccept;
            emit_cls   = frame_cls;
          end else begin
            phase_next       = PhData;
            bit_count_next   = '0;
            field_shift_next = '0;
            parity_acc_next  = 1'b0;
          end
        end
        PhData: begin
          if (count_in >= 4'd8) begin
            pattern_alive_next = byte_alive;
            if (byte_index == LW'(3)) begin
              check_byte_next = shift_in[BW-1:0];
            end
            byte_index_next = byte_index + 1'b1;
            phase_next      = PhDpar;
          end
        end
        PhDpar: begin
          if (bit_in != parity_acc) begin
            phase_next = PhIdle;
            emit       = 1'b1;
            emit_kind  = avcrx_pkg::EvParity;
          end else if (!for_us_flag) begin
            phase_next = PhAckd;
          end else if (byte_index >= length_reg) begin
            phase_next = PhIdle;
            emit       = 1'b1;
            emit_kind  = avcrx_pkg::EvAccept;
            emit_cls   = frame_cls;
          end else begin
            phase_next       = PhData;
            bit_count_next   = '0;
            field_shift_next = '0;
            parity_acc_next  = 1'b0;
            emit             = 1'b1;
            emit_kind        = avcrx_pkg::EvAck;
          end
        end
        default: phase_next = PhIdle;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PhIdle;
      bit_count     <= '0;
      field_shift   <= '0;
      parity_acc    <= 1'b0;
      directed_flag <= 1'b0;
      for_us_flag   <= 1'b0;
      master_reg    <= '0;
      slave_reg     <= '0;
      length_reg    <= '0;
      byte_index    <= '0;
      pattern_alive <= '1;
      check_byte    <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      field_shift   <= field_shift_next;
      parity_acc    <= parity_acc_next;
      directed_flag <= directed_flag_next;
      for_us_flag   <= for_us_flag_next;
      master_reg    <= master_reg_next;
      slave_reg     <= slave_reg_next;
      length_reg    <= length_reg_next;
      byte_index    <= byte_index_next;
      pattern_alive <= pattern_alive_next;
      check_byte    <= check_byte_next;
    end
  end

  // Result register: load on an event, drop once the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && emit) begin
      res_valid <= 1'b1;
    end else if (!out_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res.kind     <= emit_kind;
      res.cls      <= emit_cls;
      res.directed <= directed_flag;
      res.for_us   <= for_us_flag;
      res.master   <= master_reg;
      res.slave    <= slave_reg;
      res.length   <= length_reg;
      res.check    <= (emit_cls == avcrx_pkg::ClsCheck) ? check_byte : '0;
    end
  end

endmodule

### hw/rtl/avc_lan_frame_receiver_unit.sv
// AVC-LAN frame receiver: front end, bit queue and frame decoder.
//
// Input channel (in_valid / in_stall): one word per bit of the bus, carrying the
// measured high time pulse_ticks and frame_start, which marks the start bit and
// restarts decode. Output channel (out_valid / out_stall): one word per event:
// drive ack, frame accepted with its command class, parity error or length error.
// Most input words give no output word.
// Configuration: cfg_write with cfg_index 0 sets own_address, index 1 sets the
// one/zero pulse width limit; write only while the block is idle.
// Throughput: one input word per cycle, sustained while out_stall is low.
// An event reaches the output by way of the bit queue and then the result
// register, both of which are registered.
// Reset clears the queue, returns the decoder to waiting for a start bit and
// loads own_address 0 and a width limit of 208 ticks.
// When the receiver stalls, the result register holds, the decoder stops and the
// bit queue fills; in_stall rises once the queue holds QUEUE_DEPTH words.
module avc_lan_frame_receiver_unit #(
  parameter int QUEUE_DEPTH = avcrx_pkg::QueueDepth
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [avcrx_pkg::AddrWidth-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [avcrx_pkg::TickWidth-1:0]   pulse_ticks,
  input  logic                              frame_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [avcrx_pkg::KindWidth-1:0]   event_kind,
  output logic [avcrx_pkg::ClassWidth-1:0]  command_class,
  output logic                              is_directed,
  output logic                              addressed_to_us,
  output logic [avcrx_pkg::AddrWidth-1:0]   master_address,
  output logic [avcrx_pkg::AddrWidth-1:0]   slave_address,
  output logic [avcrx_pkg::LenWidth-1:0]    payload_length,
  output logic [avcrx_pkg::ByteWidth-1:0]   check_sequence
);

  logic                             q_full;
  logic                             push;
  avcrx_pkg::pulse_t                push_data;
  logic [avcrx_pkg::AddrWidth-1:0]  own_address;
  logic                             head_valid;
  avcrx_pkg::pulse_t                head_data;
  logic                             pop;
  avcrx_pkg::result_t               res;

  avcrx_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .pulse_ticks (pulse_ticks),
    .frame_start (frame_start),
    .q_full      (q_full),
    .in_stall    (in_stall),
    .push        (push),
    .push_data   (push_data),
    .own_address (own_address)
  );

  avcrx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  avcrx_back u_back (
    .clk         (clk),
    .rst         (rst),
    .own_address (own_address),
    .head_valid  (head_valid),
    .head_data   (head_data),
    .pop         (pop),
    .out_stall   (out_stall),
    .res_valid   (out_valid),
    .res         (res)
  );

  assign event_kind      = res.kind;
  assign command_class   = res.cls;
  assign is_directed     = res.directed;
  assign addressed_to_us = res.for_us;
  assign master_address  = res.master;
  assign slave_address   = res.slave;
  assign payload_length  = res.length;
  assign check_sequence  = res.check;

  a_class_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind != avcrx_pkg::EvAccept) |-> command_class == avcrx_pkg::ClsNone)
    else $error("command class set on a non-accept event");

  a_check_only_for_check: assert property (@(posedge clk) disable iff (rst)
    out_valid && (command_class != avcrx_pkg::ClsCheck) |-> check_sequence == '0)
    else $error("check byte reported outside a check command");

  a_accept_length_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == avcrx_pkg::EvAccept) |->
      payload_length <= avcrx_pkg::LenWidth'(avcrx_pkg::MaxMessageBytes))
    else $error("frame accepted with an oversized length");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> !pop || $past(q_full) || !$past(pop))
    else $error("input stalled while the queue was draining");

endmodule
